FILE: sv/blc_pkg.sv
// shared types, codes and tables for the button level lamp controller
// used by every module of the block; no dependencies

package blc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_SEC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FLOOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_START = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 3'd6;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	localparam logic [2:0] LEVEL_OFF  = 3'd0;
	localparam logic [2:0] LEVEL_RAMP = 3'd1;
	localparam logic [2:0] LEVEL_WRAP = 3'd7;
	localparam logic [2:0] LEVEL_TOP  = 3'd6;

	localparam logic [9:0] SECONDS_MAX = 10'd1023;
	localparam logic [7:0] RAMP_RESET  = 8'd100;

	typedef struct packed {
		logic [7:0] short_press_min;
		logic [7:0] long_press_ticks;
		logic [6:0] ticks_per_second;
		logic [9:0] timeout_seconds;
		logic [7:0] ramp_floor;
		logic [7:0] ramp_start;
		logic [3:0] ramp_step;
	} cfg_t;

	// what the front end hands to the back end for one tick
	typedef struct packed {
		logic [1:0] kind;
		logic       hold_zero;
	} qitem_t;

	function automatic logic [7:0] fixed_duty(input logic [2:0] lv);
		logic [7:0] d;
		case (lv)
			3'd2:    d = 8'd81;
			3'd3:    d = 8'd85;
			3'd4:    d = 8'd90;
			3'd5:    d = 8'd93;
			3'd6:    d = 8'd97;
			default: d = 8'd0;
		endcase
		return d;
	endfunction

	function automatic logic [5:0] led_of(input logic [2:0] lv);
		logic [5:0] b;
		case (lv)
			3'd1:    b = 6'b000001;
			3'd2:    b = 6'b000010;
			3'd3:    b = 6'b000100;
			3'd4:    b = 6'b001000;
			3'd5:    b = 6'b010000;
			3'd6:    b = 6'b100000;
			default: b = 6'b000000;
		endcase
		return b;
	endfunction

endpackage

FILE: sv/blc_front.sv
// front end: hold counter and click classification per accepted tick
// depends on blc_pkg

module blc_front import blc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       accept,
	input  logic       key_pressed,
	output qitem_t     item
);

	logic [7:0] hold_count_q;
	logic       long_latched_q;
	logic [7:0] hold_next;
	logic       latched_next;
	logic [8:0] inc;

	always_comb begin
		inc          = {1'b0, hold_count_q} + 9'd1;
		item.kind    = KIND_NONE;
		hold_next    = hold_count_q;
		latched_next = long_latched_q;
		if (key_pressed) begin
			hold_next = inc[7:0];
			if (inc >= {1'b0, cfg.long_press_ticks}) begin
				hold_next = cfg.long_press_ticks;
				if (!long_latched_q) begin
					latched_next = 1'b1;
					item.kind    = KIND_LONG;
				end
			end
		end else begin
			if (hold_count_q < cfg.long_press_ticks && hold_count_q >= cfg.short_press_min) begin
				item.kind = KIND_SHORT;
			end
			hold_next    = 8'd0;
			latched_next = 1'b0;
		end
		item.hold_zero = (hold_next == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q   <= 8'd0;
			long_latched_q <= 1'b0;
		end else if (accept) begin
			hold_count_q   <= hold_next;
			long_latched_q <= latched_next;
		end
	end

endmodule

FILE: sv/blc_queue.sv
// two-entry queue between front end and back end
// depends on blc_pkg for the entry type

module blc_queue import blc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qitem_t push_item,
	output logic   not_full,
	input  logic   pop,
	output logic   not_empty,
	output qitem_t pop_item
);

	qitem_t     mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2 || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

endmodule

FILE: sv/blc_back.sv
// back end: level sequencing, ramp, timeout, sleep and the output register
// depends on blc_pkg

module blc_back import blc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	input  qitem_t      in_item,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] out_data,
	output logic [1:0]  out_kind
);

	logic [2:0] level_q;
	logic [7:0] ramp_duty_q;
	logic [6:0] tick_in_second_q;
	logic [9:0] active_seconds_q;
	logic       pwm_running_q;
	logic [5:0] led_latch_q;
	logic       out_valid_q;
	logic [23:0] out_data_q;
	logic [1:0] out_kind_q;

	logic [2:0] lvl;
	logic [7:0] ramp;
	logic [6:0] tick;
	logic [9:0] secs;
	logic       pwm;
	logic [5:0] led;
	logic [7:0] duty;
	logic       sleep;
	logic [7:0] t;
	logic       step;

	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_kind  = out_kind_q;

	always_comb begin
		lvl   = level_q;
		ramp  = ramp_duty_q;
		tick  = tick_in_second_q;
		secs  = active_seconds_q;
		pwm   = pwm_running_q;
		led   = led_latch_q;
		duty  = 8'd0;
		sleep = 1'b0;
		t     = {1'b0, tick_in_second_q} + 8'd1;

		// seconds timer runs only while a level is active
		if (level_q != LEVEL_OFF) begin
			if (t >= {1'b0, cfg.ticks_per_second}) begin
				t = 8'd0;
				if (secs < SECONDS_MAX) secs = secs + 10'd1;
			end
			tick = t[6:0];
		end

		case (in_item.kind)
			KIND_SHORT: begin
				lvl = level_q + 3'd1;
				if (lvl == LEVEL_WRAP) begin
					lvl  = LEVEL_OFF;
					secs = 10'd0;
				end
				if (lvl == LEVEL_RAMP) ramp = cfg.ramp_start;
				if (lvl != LEVEL_OFF) pwm = 1'b1;
			end
			KIND_LONG: lvl = LEVEL_OFF;
			default: ;
		endcase

		if (lvl == LEVEL_OFF) begin
			pwm = 1'b0;
			if (in_item.hold_zero) sleep = 1'b1;
		end else if (lvl == LEVEL_RAMP) begin
			// may undershoot the floor once before the floor is held
			if (ramp > cfg.ramp_floor) begin
				ramp = (ramp > {4'd0, cfg.ramp_step}) ? ramp - {4'd0, cfg.ramp_step} : 8'd0;
				duty = ramp;
			end else begin
				duty = cfg.ramp_floor;
			end
			led = led | 6'b000001;
		end else begin
			duty = fixed_duty((lvl > LEVEL_TOP) ? LEVEL_TOP : lvl);
			led  = led | led_of((lvl > LEVEL_TOP) ? LEVEL_TOP : lvl);
		end

		if (secs >= cfg.timeout_seconds) sleep = 1'b1;

		if (sleep) begin
			pwm  = 1'b0;
			secs = 10'd0;
			lvl  = LEVEL_OFF;
			led  = 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q          <= LEVEL_OFF;
			ramp_duty_q      <= RAMP_RESET;
			tick_in_second_q <= 7'd0;
			active_seconds_q <= 10'd0;
			pwm_running_q    <= 1'b0;
			led_latch_q      <= 6'd0;
			out_valid_q      <= 1'b0;
		end else begin
			if (step) begin
				level_q          <= lvl;
				ramp_duty_q      <= ramp;
				tick_in_second_q <= tick;
				active_seconds_q <= secs;
				pwm_running_q    <= pwm;
				led_latch_q      <= led;
				out_valid_q      <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {5'd0, sleep, lvl, led, pwm, duty};
			out_kind_q <= in_item.kind;
		end
	end

	a_sleep_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[18]) |-> (out_data_q[17:15] == LEVEL_OFF
			&& out_data_q[14:9] == 6'd0 && !out_data_q[8]))
		else $error("sleep result with level, leds or pwm still set");

	a_level_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q != LEVEL_OFF) |-> pwm_running_q)
		else $error("active level without pwm running");

	a_long_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_LONG) |-> out_data_q[17:15] == LEVEL_OFF)
		else $error("long press left a level active");

endmodule

FILE: sv/button_level_lamp_controller.sv
// top level of the button level lamp controller: config registers and stream ports
// depends on blc_pkg, blc_front, blc_queue, blc_back
//
// usage:
//  s_tvalid/s_tready/s_tdata carries one 10 ms tick per transaction, bit 0 the
//  qualified button level. m_tvalid/m_tready/m_tdata/m_tuser returns exactly one
//  result per tick, in order. configuration is written through cfg_we, cfg_index
//  and cfg_wdata while no tick is in flight; indexes beyond the register list
//  are ignored.
//  a tick accepted is classified and written into the queue; the back end
//  takes it from the queue and registers its result in the output register,
//  from which it is offered. throughput: one tick per cycle while the receiver
//  does not stall, set by the back-end step feeding the output register.
//  when the receiver stalls, the output register holds its result and the
//  two-entry queue absorbs up to two more ticks before s_tready drops.
//  reset: all counters clear, the level is off, the ramp duty is 100 and the
//  registers take their defaults (5, 200, 99, 900, 77, 90, 2).

module button_level_lamp_controller import blc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] key_pressed
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [7:0] pwm_duty, [8] pwm_enabled,
	                                         // [14:9] led_bits, [17:15] current_level,
	                                         // [18] sleep_request
	output logic [1:0]            m_tuser,   // [1:0] click_kind
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t   cfg_q;
	qitem_t front_item;
	qitem_t back_item;
	logic   q_not_full;
	logic   q_not_empty;
	logic   back_ready;
	logic   accept;
	logic   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press_min  <= 8'd5;
			cfg_q.long_press_ticks <= 8'd200;
			cfg_q.ticks_per_second <= 7'd99;
			cfg_q.timeout_seconds  <= 10'd900;
			cfg_q.ramp_floor       <= 8'd77;
			cfg_q.ramp_start       <= 8'd90;
			cfg_q.ramp_step        <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_MIN:  cfg_q.short_press_min  <= cfg_wdata[7:0];
				CFG_LONG_TICKS: cfg_q.long_press_ticks <= cfg_wdata[7:0];
				CFG_TICKS_SEC:  cfg_q.ticks_per_second <= cfg_wdata[6:0];
				CFG_TIMEOUT:    cfg_q.timeout_seconds  <= cfg_wdata;
				CFG_RAMP_FLOOR: cfg_q.ramp_floor       <= cfg_wdata[7:0];
				CFG_RAMP_START: cfg_q.ramp_start       <= cfg_wdata[7:0];
				CFG_RAMP_STEP:  cfg_q.ramp_step        <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign s_tready = q_not_full;
	assign accept   = s_tvalid && q_not_full;
	assign pop      = q_not_empty && back_ready;

	blc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.key_pressed (s_tdata[0]),
		.item        (front_item)
	);

	blc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (front_item),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_item  (back_item)
	);

	blc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (q_not_empty),
		.in_item   (back_item),
		.in_ready  (back_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser)
	);

endmodule

FILE: dv/button_level_lamp_controller_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for button_level_lamp_controller: a tick-by-tick lamp
// predictor checks every result stream transaction; needs blc_pkg and the rtl

module button_level_lamp_controller_tb;
	import blc_pkg::*;

	typedef struct packed {
		logic [7:0] duty;
		logic       pwm_on;
		logic [5:0] leds;
		logic [2:0] level;
		logic       sleep;
		logic [1:0] kind;
	} lamp_out_t;

	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic                  key;
		logic                  typed;
		lamp_out_t             want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [0] key_pressed
	logic                  m_tvalid;
	logic                  m_tready;
	logic [23:0]           m_tdata;   // [7:0] pwm_duty, [8] pwm_enabled, [14:9] led_bits,
	                                  // [17:15] current_level, [18] sleep_request
	logic [1:0]            m_tuser;   // [1:0] click_kind
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	button_level_lamp_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the lamp state and its registers
	cfg_t       lamp_cfg = '{8'd5, 8'd200, 7'd99, 10'd900, 8'd77, 8'd90, 4'd2};
	logic [7:0] hold_cnt   = 8'd0;
	logic       long_seen  = 1'b0;
	logic [2:0] lamp_lvl   = LEVEL_OFF;
	logic [7:0] ramp_val   = RAMP_RESET;
	logic [6:0] sub_tick   = 7'd0;
	logic [9:0] on_seconds = 10'd0;
	logic       pwm_run    = 1'b0;
	logic [5:0] led_reg    = 6'd0;

	lamp_out_t lamp_expected_q [$];
	int        bad_cnt      = 0;
	int        results_seen = 0;
	bit        calm         = 1'b0;
	bit        long_hold_done = 1'b0;
	int        tx_idle_pct  = 25;
	int        rx_idle_pct  = 20;

	function automatic lamp_out_t predict_lamp_tick(input logic key);
		lamp_out_t  r;
		int         t;
		int         nxt;
		logic [1:0] kind;
		logic [7:0] duty;
		logic       sleep;
		kind  = KIND_NONE;
		duty  = 8'd0;
		sleep = 1'b0;
		// seconds timer runs only while a level is lit
		if (lamp_lvl != LEVEL_OFF) begin
			t = sub_tick + 1;
			if (t >= lamp_cfg.ticks_per_second) begin
				t = 0;
				if (on_seconds < SECONDS_MAX)
					on_seconds = on_seconds + 10'd1;
			end
			sub_tick = t[6:0];
		end
		if (key) begin
			nxt = hold_cnt + 1;
			if (nxt >= lamp_cfg.long_press_ticks) begin
				nxt = lamp_cfg.long_press_ticks;
				if (!long_seen) begin
					long_seen = 1'b1;
					kind = KIND_LONG;
				end
			end
			hold_cnt = nxt[7:0];
		end else begin
			if (hold_cnt < lamp_cfg.long_press_ticks && hold_cnt >= lamp_cfg.short_press_min)
				kind = KIND_SHORT;
			hold_cnt  = 8'd0;
			long_seen = 1'b0;
		end
		if (kind == KIND_SHORT) begin
			if (lamp_lvl == LEVEL_TOP) begin
				lamp_lvl   = LEVEL_OFF;
				on_seconds = 10'd0;
			end else begin
				lamp_lvl = lamp_lvl + 3'd1;
			end
			if (lamp_lvl == LEVEL_RAMP)
				ramp_val = lamp_cfg.ramp_start;
			if (lamp_lvl != LEVEL_OFF)
				pwm_run = 1'b1;
		end else if (kind == KIND_LONG) begin
			lamp_lvl = LEVEL_OFF;
		end
		if (lamp_lvl == LEVEL_OFF) begin
			pwm_run = 1'b0;
			if (hold_cnt == 8'd0)
				sleep = 1'b1;
		end else begin
			if (lamp_lvl == LEVEL_RAMP) begin
				// ramp may undershoot the floor once before the floor itself shows
				if (ramp_val > lamp_cfg.ramp_floor) begin
					ramp_val = (ramp_val > lamp_cfg.ramp_step) ?
						ramp_val - lamp_cfg.ramp_step : 8'd0;
					duty = ramp_val;
				end else begin
					duty = lamp_cfg.ramp_floor;
				end
			end else begin
				case (lamp_lvl)
					3'd2:    duty = 8'd81;
					3'd3:    duty = 8'd85;
					3'd4:    duty = 8'd90;
					3'd5:    duty = 8'd93;
					default: duty = 8'd97;
				endcase
			end
			led_reg[lamp_lvl - 3'd1] = 1'b1;
		end
		if (on_seconds >= lamp_cfg.timeout_seconds)
			sleep = 1'b1;
		if (sleep) begin
			pwm_run    = 1'b0;
			on_seconds = 10'd0;
			lamp_lvl   = LEVEL_OFF;
			led_reg    = 6'd0;
		end
		r.duty   = duty;
		r.pwm_on = pwm_run;
		r.leds   = led_reg;
		r.level  = lamp_lvl;
		r.sleep  = sleep;
		r.kind   = kind;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		return r;
	endfunction

	function automatic stim_row_t tick_row(input logic key);
		stim_row_t r;
		r = '0;
		r.key = key;
		return r;
	endfunction

	function automatic stim_row_t seen_row(input logic key, input lamp_out_t w);
		stim_row_t r;
		r = '0;
		r.key   = key;
		r.typed = 1'b1;
		r.want  = w;
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_tick(input logic key, input logic typed, input lamp_out_t want);
		lamp_out_t p;
		cfg_we <= 1'b0;
		if (!calm && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(12, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, key};
		do @(posedge clk); while (!s_tready);
		p = predict_lamp_tick(key);
		lamp_expected_q.push_back(typed ? want : p);
		@(negedge clk);
	endtask

	// stop offering ticks and wait until every result is back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (lamp_expected_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_SHORT_MIN:  lamp_cfg.short_press_min  = val[7:0];
			CFG_LONG_TICKS: lamp_cfg.long_press_ticks = val[7:0];
			CFG_TICKS_SEC:  lamp_cfg.ticks_per_second = val[6:0];
			CFG_TIMEOUT:    lamp_cfg.timeout_seconds  = val[9:0];
			CFG_RAMP_FLOOR: lamp_cfg.ramp_floor       = val[7:0];
			CFG_RAMP_START: lamp_cfg.ramp_start       = val[7:0];
			CFG_RAMP_STEP:  lamp_cfg.ramp_step        = val[3:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin : result_check
		lamp_out_t got;
		lamp_out_t w;
		if (arst_n && m_tvalid && m_tready) begin
			got.duty   = m_tdata[7:0];
			got.pwm_on = m_tdata[8];
			got.leds   = m_tdata[14:9];
			got.level  = m_tdata[17:15];
			got.sleep  = m_tdata[18];
			got.kind   = m_tuser;
			results_seen++;
			if (lamp_expected_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("unexpected result: duty=%0d on=%b leds=%b level=%0d sleep=%b kind=%0d",
						got.duty, got.pwm_on, got.leds, got.level, got.sleep, got.kind);
			end else begin
				w = lamp_expected_q.pop_front();
				if (got !== w) begin
					bad_cnt++;
					if (bad_cnt <= 10) begin
						$display("mismatch at result %0d", results_seen);
						$display("  expected duty=%0d on=%b leds=%b level=%0d sleep=%b kind=%0d",
							w.duty, w.pwm_on, w.leds, w.level, w.sleep, w.kind);
						$display("  actual   duty=%0d on=%b leds=%b level=%0d sleep=%b kind=%0d",
							got.duty, got.pwm_on, got.leds, got.level, got.sleep, got.kind);
					end
				end
			end
		end
	end

	// receiver side: random stall bursts plus one long hold-off
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 80) begin
				long_hold_done = 1'b1;
				stall_left = 47;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(99) < rx_idle_pct) begin
				stall_left = $urandom_range(11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		stim_row_t   dir_tab [$];
		int unsigned sh;
		int unsigned lg;
		int unsigned h;
		int unsigned g;
		int unsigned mode;
		int unsigned phase_items;
		int unsigned rand_items;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'd0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle after reset sleeps at once
		dir_tab.push_back(seen_row(1'b0, {8'd0, 1'b0, 6'd0, LEVEL_OFF, 1'b1, KIND_NONE}));
		dir_tab.push_back(reg_row(CFG_SHORT_MIN, 10'd1));
		dir_tab.push_back(reg_row(CFG_LONG_TICKS, 10'd3));
		dir_tab.push_back(reg_row(CFG_TICKS_SEC, 10'd1));
		dir_tab.push_back(reg_row(CFG_TIMEOUT, 10'd1023));
		dir_tab.push_back(reg_row(CFG_RAMP_FLOOR, 10'd0));
		dir_tab.push_back(reg_row(CFG_RAMP_START, 10'd20));
		dir_tab.push_back(reg_row(CFG_RAMP_STEP, 10'd15));
		// click into the ramp, which then saturates at zero
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(tick_row(1'b0));
		dir_tab.push_back(tick_row(1'b0));
		dir_tab.push_back(tick_row(1'b0));
		// second click to level two
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(tick_row(1'b0));
		// long press: level off but leds stay lit, reported once
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(seen_row(1'b1, {8'd0, 1'b0, 6'b000011, LEVEL_OFF, 1'b0, KIND_LONG}));
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(seen_row(1'b0, {8'd0, 1'b0, 6'd0, LEVEL_OFF, 1'b1, KIND_NONE}));
		// ramp undershoots the floor, then holds the floor
		dir_tab.push_back(reg_row(CFG_RAMP_FLOOR, 10'd77));
		dir_tab.push_back(reg_row(CFG_RAMP_START, 10'd82));
		dir_tab.push_back(reg_row(CFG_RAMP_STEP, 10'd2));
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(tick_row(1'b0));
		dir_tab.push_back(tick_row(1'b0));
		dir_tab.push_back(tick_row(1'b0));
		dir_tab.push_back(tick_row(1'b0));
		// timeout sleep while lit
		dir_tab.push_back(reg_row(CFG_TIMEOUT, 10'd1));
		dir_tab.push_back(tick_row(1'b0));
		// limit lowered under a running hold count
		dir_tab.push_back(reg_row(CFG_LONG_TICKS, 10'd255));
		dir_tab.push_back(reg_row(CFG_SHORT_MIN, 10'd255));
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(tick_row(1'b1));
		dir_tab.push_back(reg_row(CFG_LONG_TICKS, 10'd2));
		dir_tab.push_back(seen_row(1'b1, {8'd0, 1'b0, 6'd0, LEVEL_OFF, 1'b0, KIND_LONG}));
		dir_tab.push_back(seen_row(1'b0, {8'd0, 1'b0, 6'd0, LEVEL_OFF, 1'b1, KIND_NONE}));

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_reg) begin
				settle();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				push_tick(dir_tab[i].key, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		rand_items = 0;
		while (rand_items < 650) begin
			settle();
			calm = (rand_items >= 560);
			sh = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 255 : 1) : $urandom_range(4, 1);
			lg = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 255 : 2) : sh + $urandom_range(8, 1);
			if (lg > 255)
				lg = 255;
			write_reg(CFG_SHORT_MIN, CFG_DATA_W'(sh));
			write_reg(CFG_LONG_TICKS, CFG_DATA_W'(lg));
			write_reg(CFG_TICKS_SEC, CFG_DATA_W'(($urandom_range(4) == 0) ?
				($urandom_range(1) ? 127 : 1) : $urandom_range(4, 1)));
			write_reg(CFG_TIMEOUT, CFG_DATA_W'(($urandom_range(4) == 0) ?
				($urandom_range(1) ? 1023 : 1) : $urandom_range(40, 1)));
			write_reg(CFG_RAMP_FLOOR, CFG_DATA_W'(($urandom_range(4) == 0) ?
				($urandom_range(1) ? 255 : 0) : $urandom_range(100, 60)));
			write_reg(CFG_RAMP_START, CFG_DATA_W'(($urandom_range(4) == 0) ?
				($urandom_range(1) ? 255 : 0) : $urandom_range(110, 70)));
			write_reg(CFG_RAMP_STEP, CFG_DATA_W'(($urandom_range(4) == 0) ?
				($urandom_range(1) ? 15 : 1) : $urandom_range(5, 1)));
			case ($urandom_range(2))
				0:       tx_idle_pct = 0;
				1:       tx_idle_pct = 15;
				default: tx_idle_pct = 40;
			endcase
			case ($urandom_range(2))
				0:       rx_idle_pct = 0;
				1:       rx_idle_pct = 10;
				default: rx_idle_pct = 30;
			endcase
			phase_items = 0;
			while (phase_items < 60) begin
				mode = $urandom_range(9);
				// mostly clicks, some long presses, the rest short noise
				if (mode < 7 && sh < lg)
					h = $urandom_range((lg - 1 < sh + 6) ? lg - 1 : sh + 6, sh);
				else if (mode < 8 && lg <= 32)
					h = $urandom_range(lg + 4, lg);
				else
					h = $urandom_range(4, 1);
				g = ($urandom_range(4) == 0) ? $urandom_range(20, 4) : $urandom_range(3, 1);
				for (int k = 0; k < h + g; k++) begin
					if (mode == 9)
						push_tick(1'($urandom_range(1)), 1'b0, '0);
					else
						push_tick(k < h, 1'b0, '0);
				end
				phase_items += h + g;
				rand_items  += h + g;
			end
		end

		settle();
		repeat (10) @(negedge clk);
		if (bad_cnt == 0 && lamp_expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
